FILE: src/dms_pkg.sv
`timescale 1ns / 1ps

package dms_pkg;

  localparam int MaxDigits = 32;
  localparam int DigitW    = 4;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int IdxW      = $clog2(MaxDigits);

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [CntW-1:0]   count_t;
  typedef logic [IdxW-1:0]   idx_t;

  localparam digit_t DigitMax = digit_t'(9);
  localparam digit_t Radix    = digit_t'(10);

  // Control bundle from the sequencer to one digit store.
  typedef struct packed {
    logic append;
    logic clear;
    idx_t rd_addr;
  } store_ctrl_t;

endpackage

FILE: src/dms_digit_store.sv
`timescale 1ns / 1ps

module dms_digit_store import dms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  store_ctrl_t ctrl_i,
  input  digit_t      digit_i,
  output digit_t      rd_data_o,
  output count_t      count_o,
  output logic        drop_o
);

  digit_t mem [MaxDigits];
  count_t count_q, count_d;
  digit_t rd_data_q;
  digit_t digit_sat;
  logic   full;
  logic   store_en;

  assign digit_sat = (digit_i > DigitMax) ? DigitMax : digit_i;
  assign full      = (count_q >= count_t'(MaxDigits));
  // A leading zero is not stored, so the count is the significant length.
  assign store_en  = ctrl_i.append && !full && !(count_q == '0 && digit_sat == '0);
  assign drop_o    = ctrl_i.append && full;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (store_en) begin
      count_d = count_q + count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en && !ctrl_i.clear) begin
      mem[count_q[IdxW-1:0]] <= digit_sat;
    end
    rd_data_q <= mem[ctrl_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

FILE: src/decimal_magnitude_subtractor.sv
`timescale 1ns / 1ps

// Decimal magnitude subtractor. Digits of the two numbers are taken one per
// transaction (start high while busy is low), most significant digit first,
// and each goes to the number that action selects; a digit of the second
// number marked last starts the computation and raises busy. The block then
// walks the stored digits with one read port per number: after setup, a
// compare pass over the leading digits while the lengths are equal, a
// subtract pass over every digit of the larger number, and an emit pass
// over the result digits. Results appear one digit per strobe_o pulse, most
// significant first, with last_digit_o on the final one, and must be taken in
// that cycle as there is no back-pressure. busy falls in the cycle after the
// final digit, when both numbers and the overflow flag have been cleared for
// the next pair.
module decimal_magnitude_subtractor import dms_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  logic   action_i,
  input  digit_t digit_i,
  input  logic   last_i,
  output logic   strobe_o,
  output logic   negative_o,
  output digit_t diff_digit_o,
  output logic   overflow_o,
  output logic   last_digit_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CMP      = 4'd1;
  localparam logic [3:0] S_CMP_RD   = 4'd2;
  localparam logic [3:0] S_CMP_CHK  = 4'd3;
  localparam logic [3:0] S_SUB_INIT = 4'd4;
  localparam logic [3:0] S_SUB_RD   = 4'd5;
  localparam logic [3:0] S_SUB_CALC = 4'd6;
  localparam logic [3:0] S_EMIT_RD  = 4'd7;
  localparam logic [3:0] S_EMIT_OUT = 4'd8;
  localparam logic [3:0] S_ZERO     = 4'd9;

  logic [3:0]  state_q, state_d;
  logic        neg_q, neg_d;
  logic        trunc_q, trunc_d;
  logic        borrow_q, borrow_d;
  count_t      i_q, i_d;
  idx_t        top_q, top_d;
  idx_t        e_q, e_d;

  store_ctrl_t ctrl1, ctrl2;
  digit_t      rd1, rd2;
  count_t      cnt1, cnt2;
  logic        drop1, drop2;

  logic        accept;
  logic        finish;
  count_t      lbig, lsmall;
  count_t      a1, a2;
  digit_t      big_dig, small_dig;
  logic [DigitW:0] diff_raw;
  digit_t      res_dig;
  logic        res_wr;

  digit_t      res_mem [MaxDigits];
  digit_t      res_rd_q;

  assign accept = start && !busy;
  assign finish = (state_q == S_ZERO) || (state_q == S_EMIT_OUT && e_q == '0);

  assign lbig   = neg_q ? cnt2 : cnt1;
  assign lsmall = neg_q ? cnt1 : cnt2;

  // During the compare pass both stores read the same place from the top;
  // during the subtract pass each is read from its own least significant end.
  assign a1 = cnt1 - count_t'(1) - i_q;
  assign a2 = cnt2 - count_t'(1) - i_q;

  always_comb begin
    ctrl1.append  = accept && !action_i;
    ctrl2.append  = accept && action_i;
    ctrl1.clear   = finish;
    ctrl2.clear   = finish;
    ctrl1.rd_addr = i_q[IdxW-1:0];
    ctrl2.rd_addr = i_q[IdxW-1:0];
    if (state_q == S_SUB_RD || state_q == S_SUB_CALC) begin
      ctrl1.rd_addr = a1[IdxW-1:0];
      ctrl2.rd_addr = a2[IdxW-1:0];
    end
  end

  dms_digit_store u_first (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl1),
    .digit_i   (digit_i),
    .rd_data_o (rd1),
    .count_o   (cnt1),
    .drop_o    (drop1)
  );

  dms_digit_store u_second (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl2),
    .digit_i   (digit_i),
    .rd_data_o (rd2),
    .count_o   (cnt2),
    .drop_o    (drop2)
  );

  // One decimal digit of the difference with borrow in and out.
  assign big_dig   = neg_q ? rd2 : rd1;
  assign small_dig = (i_q < lsmall) ? (neg_q ? rd1 : rd2) : '0;
  assign diff_raw  = {1'b0, big_dig} - {1'b0, small_dig} - {{DigitW{1'b0}}, borrow_q};
  assign res_dig   = diff_raw[DigitW] ? (diff_raw[DigitW-1:0] + Radix) : diff_raw[DigitW-1:0];
  assign res_wr    = (state_q == S_SUB_CALC);

  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    trunc_d  = trunc_q;
    borrow_d = borrow_q;
    i_d      = i_q;
    top_d    = top_q;
    e_d      = e_q;

    if (drop1 || drop2) begin
      trunc_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept && action_i && last_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        i_d = '0;
        if (cnt1 != cnt2) begin
          neg_d   = (cnt2 > cnt1);
          state_d = S_SUB_INIT;
        end else if (cnt1 == '0) begin
          neg_d   = 1'b0;
          state_d = S_ZERO;
        end else begin
          state_d = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        state_d = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (rd1 != rd2) begin
          neg_d   = (rd2 > rd1);
          state_d = S_SUB_INIT;
        end else if (i_q == cnt1 - count_t'(1)) begin
          neg_d   = 1'b0;
          state_d = S_SUB_INIT;
        end else begin
          i_d     = i_q + count_t'(1);
          state_d = S_CMP_RD;
        end
      end
      S_SUB_INIT: begin
        i_d      = '0;
        borrow_d = 1'b0;
        top_d    = '0;
        state_d  = S_SUB_RD;
      end
      S_SUB_RD: begin
        state_d = S_SUB_CALC;
      end
      S_SUB_CALC: begin
        borrow_d = diff_raw[DigitW];
        if (res_dig != '0) begin
          top_d = i_q[IdxW-1:0];
        end
        if (i_q == lbig - count_t'(1)) begin
          e_d     = top_d;
          state_d = S_EMIT_RD;
        end else begin
          i_d     = i_q + count_t'(1);
          state_d = S_SUB_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (e_q == '0) begin
          trunc_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          e_d     = e_q - idx_t'(1);
          state_d = S_EMIT_RD;
        end
      end
      S_ZERO: begin
        trunc_d = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      neg_q    <= 1'b0;
      trunc_q  <= 1'b0;
      borrow_q <= 1'b0;
      i_q      <= '0;
      top_q    <= '0;
      e_q      <= '0;
    end else begin
      state_q  <= state_d;
      neg_q    <= neg_d;
      trunc_q  <= trunc_d;
      borrow_q <= borrow_d;
      i_q      <= i_d;
      top_q    <= top_d;
      e_q      <= e_d;
    end
  end

  // The difference is built least significant digit first and read back
  // from the highest non-zero digit downwards.
  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_mem[i_q[IdxW-1:0]] <= res_dig;
    end
    res_rd_q <= res_mem[e_q];
  end

  assign busy         = (state_q != S_IDLE);
  assign strobe_o     = (state_q == S_EMIT_OUT) || (state_q == S_ZERO);
  assign negative_o   = neg_q;
  assign overflow_o   = trunc_q;
  assign diff_digit_o = (state_q == S_ZERO) ? '0 : res_rd_q;
  assign last_digit_o = (state_q == S_ZERO) || (e_q == '0);

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy)
    else $error("Result strobe outside a computation.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_digit_o |=> !busy && cnt1 == '0 && cnt2 == '0 && !overflow_o)
    else $error("Block not cleared after the final result digit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> diff_digit_o <= DigitMax)
    else $error("Result digit is not decimal.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && negative_o |-> !(state_q == S_ZERO))
    else $error("Zero result flagged as negative.");
`endif

endmodule
